@@ rtl/core/ph_sensor_average_calibrate_macros.svh @@
// Assertion macros for the pH sensor averager and calibrator.
// Included by modules that carry concurrent assertions; needs clk and rst in scope.
`ifndef PH_SENSOR_AVERAGE_CALIBRATE_MACROS_SVH
`define PH_SENSOR_AVERAGE_CALIBRATE_MACROS_SVH

`ifndef SYNTH
// Condition that must hold at every clock edge outside reset.
`define PHSAC_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ph_sensor_average_calibrate: assertion failed");
// Antecedent at one edge implies the consequent at the next edge.
`define PHSAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ph_sensor_average_calibrate: assertion failed");
`else
`define PHSAC_ASSERT(label, cond)
`define PHSAC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/phsac_pkg.sv @@
// Shared types and constants for the pH sensor averager and calibrator.
// No dependencies; used by every module of the block.
package phsac_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned AVG_W      = 12;
  localparam int unsigned PH_W       = 11;
  localparam int unsigned GAIN_W     = 18;
  localparam int unsigned FAULT_W    = 2;
  localparam int unsigned CAT_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;

  localparam int unsigned SAMPLES_DEFAULT = 10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_CODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACID_ANCHOR_PH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACID_GAIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ANCHOR_CODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ANCHOR_PH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_GAIN        = 3'd5;

  // Fault codes.
  localparam logic [FAULT_W-1:0] FAULT_OK   = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_LOW  = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_HIGH = 2'd2;

  // Fault limits on the averaged code.
  localparam logic [AVG_W-1:0] AVG_LOW_LIMIT  = 12'd50;
  localparam logic [AVG_W-1:0] AVG_HIGH_LIMIT = 12'd4000;

  // pH categories.
  localparam logic [CAT_W-1:0] CAT_VERY_ACID     = 3'd0;
  localparam logic [CAT_W-1:0] CAT_ACID          = 3'd1;
  localparam logic [CAT_W-1:0] CAT_SLIGHTLY_ACID = 3'd2;
  localparam logic [CAT_W-1:0] CAT_NEUTRAL       = 3'd3;
  localparam logic [CAT_W-1:0] CAT_SLIGHTLY_BASE = 3'd4;
  localparam logic [CAT_W-1:0] CAT_BASE          = 3'd5;
  localparam logic [CAT_W-1:0] CAT_VERY_BASE     = 3'd6;

  // Reset values of the calibration registers.
  localparam logic [AVG_W-1:0]         BREAK_CODE_RST       = 12'd3115;
  localparam logic [PH_W-1:0]          ACID_ANCHOR_PH_RST   = 11'd686;
  localparam logic signed [GAIN_W-1:0] ACID_GAIN_RST        = -18'sd28134;
  localparam logic [AVG_W-1:0]         BASE_ANCHOR_CODE_RST = 12'd2513;
  localparam logic [PH_W-1:0]          BASE_ANCHOR_PH_RST   = 11'd918;
  localparam logic signed [GAIN_W-1:0] BASE_GAIN_RST        = -18'sd25263;

  typedef struct packed {
    logic [AVG_W-1:0]         break_code;
    logic [PH_W-1:0]          acid_anchor_ph;
    logic signed [GAIN_W-1:0] acid_gain;
    logic [AVG_W-1:0]         base_anchor_code;
    logic [PH_W-1:0]          base_anchor_ph;
    logic signed [GAIN_W-1:0] base_gain;
  } cfg_t;

  // A completed group sum on its way to the divider.
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } sum_word_t;

  // An averaged code on its way to the calibrator.
  typedef struct packed {
    logic             valid;
    logic [AVG_W-1:0] avg;
  } avg_word_t;

endpackage

@@ rtl/core/phsac_accum.sv @@
// Sample accumulator: sums SAMPLES readings and hands the group sum onward.
// Depends on phsac_pkg.
module phsac_accum #(
  parameter int unsigned SAMPLES = phsac_pkg::SAMPLES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [phsac_pkg::SAMPLE_W-1:0]  sample,
  output phsac_pkg::sum_word_t            sum_word,
  input  logic                            sum_ready
);

  localparam int unsigned CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES - 1);

  logic [CNT_W-1:0]            count;
  logic [phsac_pkg::SUM_W-1:0] sum;
  logic [phsac_pkg::SUM_W-1:0] sum_next;
  logic                        last;
  logic                        hold_ready;
  logic                        accept;

  assign last       = (count == LAST);
  assign hold_ready = !sum_word.valid || sum_ready;
  assign in_ready   = !last || hold_ready;
  assign accept     = in_valid && in_ready;
  assign sum_next   = sum + phsac_pkg::SUM_W'(sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      sum            <= '0;
      sum_word.valid <= 1'b0;
    end else begin
      if (hold_ready) begin
        sum_word.valid <= accept && last;
      end
      if (accept) begin
        if (last) begin
          sum_word.sum <= sum_next;
          sum          <= '0;
          count        <= '0;
        end else begin
          sum   <= sum_next;
          count <= count + 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/core/phsac_divide.sv @@
// Constant divider: group sum divided by SAMPLES through a reciprocal multiply.
// Depends on phsac_pkg.
module phsac_divide #(
  parameter int unsigned SAMPLES = phsac_pkg::SAMPLES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  phsac_pkg::sum_word_t sum_word,
  output logic                 sum_ready,
  output phsac_pkg::avg_word_t avg_word,
  input  logic                 avg_ready
);

  // A rounded-up reciprocal is exact when the shift covers the sum width
  // plus the bits of the divisor.
  localparam int unsigned DIV_SHIFT = phsac_pkg::SUM_W + 5;
  localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
  localparam int unsigned PROD_W    = phsac_pkg::SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

  logic [PROD_W-1:0] quot_full;

  assign sum_ready = !avg_word.valid || avg_ready;
  assign quot_full = PROD_W'(sum_word.sum) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_word.valid <= 1'b0;
    end else if (sum_ready) begin
      avg_word.valid <= sum_word.valid;
      if (sum_word.valid) begin
        avg_word.avg <= quot_full[DIV_SHIFT +: phsac_pkg::AVG_W];
      end
    end
  end

endmodule

@@ rtl/core/phsac_calib.sv @@
// Two-segment calibration, rounding, saturation, fault check and category.
// Depends on phsac_pkg; holds the product stage and the result register.
module phsac_calib (
  input  logic                            clk,
  input  logic                            rst,
  input  phsac_pkg::cfg_t                 cfg,
  input  phsac_pkg::avg_word_t            avg_word,
  output logic                            avg_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [phsac_pkg::AVG_W-1:0]     avg_code,
  output logic [phsac_pkg::PH_W-1:0]      ph_centi,
  output logic [phsac_pkg::FAULT_W-1:0]   fault,
  output logic [phsac_pkg::CAT_W-1:0]     category
);

  localparam int unsigned DIFF_W = phsac_pkg::AVG_W + 1;
  localparam int unsigned MUL_W  = phsac_pkg::GAIN_W + DIFF_W;
  localparam int unsigned V_W    = 32;

  function automatic logic [phsac_pkg::CAT_W-1:0] classify(
    input logic [phsac_pkg::PH_W-1:0] ph
  );
    if (ph < 11'd300) return phsac_pkg::CAT_VERY_ACID;
    if (ph < 11'd500) return phsac_pkg::CAT_ACID;
    if (ph < 11'd650) return phsac_pkg::CAT_SLIGHTLY_ACID;
    if (ph <= 11'd750) return phsac_pkg::CAT_NEUTRAL;
    if (ph <= 11'd900) return phsac_pkg::CAT_SLIGHTLY_BASE;
    if (ph <= 11'd1200) return phsac_pkg::CAT_BASE;
    return phsac_pkg::CAT_VERY_BASE;
  endfunction

  // Product stage registers.
  logic                             prod_valid;
  logic signed [MUL_W-1:0]          prod;
  logic [phsac_pkg::PH_W-1:0]       prod_anchor_ph;
  logic [phsac_pkg::AVG_W-1:0]      prod_avg;

  logic                             out_free;
  logic                             acid_seg;
  logic [phsac_pkg::AVG_W-1:0]      seg_code;
  logic [phsac_pkg::PH_W-1:0]       seg_ph;
  logic signed [phsac_pkg::GAIN_W-1:0] seg_gain;
  logic signed [DIFF_W-1:0]         diff;
  logic signed [MUL_W-1:0]          prod_next;
  logic signed [V_W-1:0]            v;
  logic [phsac_pkg::PH_W-1:0]       ph_next;
  logic [phsac_pkg::FAULT_W-1:0]    fault_next;

  assign out_free  = !out_valid || out_ready;
  assign avg_ready = !prod_valid || out_free;

  always_comb begin
    acid_seg  = (avg_word.avg >= cfg.break_code);
    seg_code  = acid_seg ? cfg.break_code     : cfg.base_anchor_code;
    seg_ph    = acid_seg ? cfg.acid_anchor_ph : cfg.base_anchor_ph;
    seg_gain  = acid_seg ? cfg.acid_gain      : cfg.base_gain;
    diff      = $signed({1'b0, avg_word.avg}) - $signed({1'b0, seg_code});
    prod_next = MUL_W'(seg_gain) * MUL_W'(diff);
  end

  always_comb begin
    v = $signed({5'd0, prod_anchor_ph, 16'd0}) + $signed({prod[MUL_W-1], prod})
        + 32'sd32768;
    if (v[V_W-1]) begin
      ph_next = '0;
    end else if (v[V_W-2:27] != '0) begin
      ph_next = '1;
    end else begin
      ph_next = v[26:16];
    end
    if (prod_avg < phsac_pkg::AVG_LOW_LIMIT) begin
      fault_next = phsac_pkg::FAULT_LOW;
    end else if (prod_avg > phsac_pkg::AVG_HIGH_LIMIT) begin
      fault_next = phsac_pkg::FAULT_HIGH;
    end else begin
      fault_next = phsac_pkg::FAULT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (avg_ready) begin
        prod_valid <= avg_word.valid;
        if (avg_word.valid) begin
          prod           <= prod_next;
          prod_anchor_ph <= seg_ph;
          prod_avg       <= avg_word.avg;
        end
      end
      if (out_free) begin
        out_valid <= prod_valid;
        if (prod_valid) begin
          avg_code <= prod_avg;
          ph_centi <= ph_next;
          fault    <= fault_next;
          category <= (fault_next == phsac_pkg::FAULT_OK) ? classify(ph_next)
                                                          : phsac_pkg::CAT_VERY_ACID;
        end
      end
    end
  end

endmodule

@@ rtl/core/ph_sensor_average_calibrate.sv @@
// pH probe sample averager with two-segment linear calibration (top level).
// Depends on phsac_pkg, phsac_accum, phsac_divide, phsac_calib and the macro header.
//
// Usage: raw 12-bit ADC readings arrive one word per handshake on the
// in_valid/in_ready channel. Every SAMPLES accepted words form a group whose
// truncated average, calibrated centi-pH value, fault code and pH category
// leave as one result word on the out_valid/out_ready channel. All other
// input words give no result.
// Calibration registers are written through cfg_valid/cfg_ready with a
// register index and data; the port is always ready, and writes are meant to
// happen while no group is in flight. Unknown indexes are ignored.
// After the edge that accepts the last sample of a group, its result passes
// the sum, divide, product and result registers. Throughput: one sample per
// cycle while in_ready is high; one result per SAMPLES samples.
// Reset clears the running sum and count, empties the pipeline and loads the
// default calibration. When the receiver stalls, the result holds and the
// stages behind it keep filling; in_ready drops only while the result is
// stalled, every stage holds a group and the accumulator is waiting for the
// final sample of another group.
`include "ph_sensor_average_calibrate_macros.svh"
module ph_sensor_average_calibrate #(
  parameter int unsigned SAMPLES = phsac_pkg::SAMPLES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [phsac_pkg::SAMPLE_W-1:0]    sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [phsac_pkg::AVG_W-1:0]       avg_code,
  output logic [phsac_pkg::PH_W-1:0]        ph_centi,
  output logic [phsac_pkg::FAULT_W-1:0]     fault,
  output logic [phsac_pkg::CAT_W-1:0]       category,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [phsac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [phsac_pkg::CFG_DATA_W-1:0]  cfg_data
);

  phsac_pkg::cfg_t      cfg;
  phsac_pkg::sum_word_t sum_word;
  phsac_pkg::avg_word_t avg_word;
  logic                 sum_ready;
  logic                 avg_ready;

  // Register writes keep only the register's own width; the gains take the
  // full 18-bit data word as a two's complement value.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.break_code       <= phsac_pkg::BREAK_CODE_RST;
      cfg.acid_anchor_ph   <= phsac_pkg::ACID_ANCHOR_PH_RST;
      cfg.acid_gain        <= phsac_pkg::ACID_GAIN_RST;
      cfg.base_anchor_code <= phsac_pkg::BASE_ANCHOR_CODE_RST;
      cfg.base_anchor_ph   <= phsac_pkg::BASE_ANCHOR_PH_RST;
      cfg.base_gain        <= phsac_pkg::BASE_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        phsac_pkg::REG_BREAK_CODE: begin
          cfg.break_code <= cfg_data[phsac_pkg::AVG_W-1:0];
        end
        phsac_pkg::REG_ACID_ANCHOR_PH: begin
          cfg.acid_anchor_ph <= cfg_data[phsac_pkg::PH_W-1:0];
        end
        phsac_pkg::REG_ACID_GAIN: begin
          cfg.acid_gain <= $signed(cfg_data[phsac_pkg::GAIN_W-1:0]);
        end
        phsac_pkg::REG_BASE_ANCHOR_CODE: begin
          cfg.base_anchor_code <= cfg_data[phsac_pkg::AVG_W-1:0];
        end
        phsac_pkg::REG_BASE_ANCHOR_PH: begin
          cfg.base_anchor_ph <= cfg_data[phsac_pkg::PH_W-1:0];
        end
        phsac_pkg::REG_BASE_GAIN: begin
          cfg.base_gain <= $signed(cfg_data[phsac_pkg::GAIN_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  // Accumulator: running sum and count; the completed group sum is registered.
  phsac_accum #(
    .SAMPLES (SAMPLES)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .sum_word  (sum_word),
    .sum_ready (sum_ready)
  );

  // Divider: reciprocal multiply of the group sum gives the truncated average.
  phsac_divide #(
    .SAMPLES (SAMPLES)
  ) u_divide (
    .clk       (clk),
    .rst       (rst),
    .sum_word  (sum_word),
    .sum_ready (sum_ready),
    .avg_word  (avg_word),
    .avg_ready (avg_ready)
  );

  // Calibrator: segment select and gain product, then rounding, saturation,
  // fault check and category into the result register.
  phsac_calib u_calib (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .avg_word  (avg_word),
    .avg_ready (avg_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .avg_code  (avg_code),
    .ph_centi  (ph_centi),
    .fault     (fault),
    .category  (category)
  );

  // A faulted result always reports the lowest category.
  `PHSAC_ASSERT(a_fault_category, !out_valid || fault == phsac_pkg::FAULT_OK || category == phsac_pkg::CAT_VERY_ACID)
  // Fault codes agree with the average that is delivered with them.
  `PHSAC_ASSERT(a_fault_low, !out_valid || fault != phsac_pkg::FAULT_LOW || avg_code < phsac_pkg::AVG_LOW_LIMIT)
  `PHSAC_ASSERT(a_fault_high, !out_valid || fault != phsac_pkg::FAULT_HIGH || avg_code > phsac_pkg::AVG_HIGH_LIMIT)
  // Input back pressure only ever comes from a stalled, full result register.
  `PHSAC_ASSERT(a_stall_source, in_ready || (out_valid && !out_ready))
  // A stalled result is still there in the next cycle.
  `PHSAC_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid)

endmodule

@@ dv/ph_sensor_average_calibrate_test.sv @@
// Self-checking testbench for the pH probe averager and two-segment calibrator.
// Needs phsac_pkg and the ph_sensor_average_calibrate RTL; reads no files.
// A table of directed groups and register writes is followed by random phases.
module ph_sensor_average_calibrate_test;
  timeunit 1ns;
  timeprecision 1ps;

  import phsac_pkg::*;

  localparam int unsigned GROUP_LEN = SAMPLES_DEFAULT;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // One result word as the block presents it.
  typedef struct packed {
    logic [AVG_W-1:0]   avg;
    logic [PH_W-1:0]    ph;
    logic [FAULT_W-1:0] fault;
    logic [CAT_W-1:0]   cat;
  } reading_t;

  // A row of the directed plan: either a register write or a whole group of
  // samples. A group row uses one value for every sample, or a ramp of
  // value, value+1, ... so that the average has a fraction to truncate.
  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_PREDICT,
    ROW_KNOWN
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  ramp;
    reading_t              known;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [AVG_W-1:0]      avg_code;
  logic [PH_W-1:0]       ph_centi;
  logic [FAULT_W-1:0]    fault;
  logic [CAT_W-1:0]      category;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: the calibration as the block should hold it, and the
  // running group sum and count.
  cfg_t              cal;
  logic [SUM_W-1:0]  grp_sum = '0;
  logic [3:0]        grp_count = '0;
  reading_t          pending_readings[$];
  int unsigned       mismatches = 0;
  bit                steady = 1'b0;

  // Directed plan. Results are typed in where the calibration makes them
  // obvious: a code sitting on an anchor, or zero gains, where the output is
  // just the anchor value. Everything else goes through the predictor.
  step_t plan [26] = '{
    // Reset calibration: both anchors land exactly on their anchor pH.
    '{ROW_KNOWN,   '0, 18'd3115, 1'b0, '{12'd3115, 11'd686, FAULT_OK, CAT_NEUTRAL}},
    '{ROW_KNOWN,   '0, 18'd2513, 1'b0, '{12'd2513, 11'd918, FAULT_OK, CAT_BASE}},
    '{ROW_PREDICT, '0, 18'd0,    1'b0, '0},
    '{ROW_PREDICT, '0, 18'd4095, 1'b0, '0},
    '{ROW_PREDICT, '0, 18'd3114, 1'b0, '0},
    // Flatten both segments: acid side pinned high, base side pinned low.
    '{ROW_WRITE, REG_ACID_GAIN,      18'd0,    1'b0, '0},
    '{ROW_WRITE, REG_BASE_GAIN,      18'd0,    1'b0, '0},
    '{ROW_WRITE, REG_ACID_ANCHOR_PH, 18'd2047, 1'b0, '0},
    '{ROW_WRITE, REG_BASE_ANCHOR_PH, 18'd0,    1'b0, '0},
    '{ROW_KNOWN, '0, 18'd0,    1'b0, '{12'd0,    11'd0,    FAULT_LOW,  CAT_VERY_ACID}},
    '{ROW_KNOWN, '0, 18'd4095, 1'b0, '{12'd4095, 11'd2047, FAULT_HIGH, CAT_VERY_ACID}},
    '{ROW_KNOWN, '0, 18'd3115, 1'b0, '{12'd3115, 11'd2047, FAULT_OK,   CAT_VERY_BASE}},
    '{ROW_KNOWN, '0, 18'd3114, 1'b0, '{12'd3114, 11'd0,    FAULT_OK,   CAT_VERY_ACID}},
    // Ramps around both fault limits; the averages truncate from x.5.
    '{ROW_KNOWN, '0, 18'd45,   1'b1, '{12'd49,   11'd0,    FAULT_LOW,  CAT_VERY_ACID}},
    '{ROW_KNOWN, '0, 18'd46,   1'b1, '{12'd50,   11'd0,    FAULT_OK,   CAT_VERY_ACID}},
    '{ROW_KNOWN, '0, 18'd3996, 1'b1, '{12'd4000, 11'd2047, FAULT_OK,   CAT_VERY_BASE}},
    '{ROW_KNOWN, '0, 18'd3997, 1'b1, '{12'd4001, 11'd2047, FAULT_HIGH, CAT_VERY_ACID}},
    // Oversized data keeps only the register width; spare indexes are dropped.
    '{ROW_WRITE, REG_BREAK_CODE, 18'h3F000, 1'b0, '0},
    '{ROW_WRITE, REG_SPARE_LO,   18'h00000, 1'b0, '0},
    '{ROW_WRITE, REG_SPARE_HI,   18'h3FFFF, 1'b0, '0},
    '{ROW_KNOWN, '0, 18'd0, 1'b0, '{12'd0, 11'd2047, FAULT_LOW, CAT_VERY_ACID}},
    // Gain extremes, most negative then most positive.
    '{ROW_WRITE, REG_ACID_GAIN,        18'h20000, 1'b0, '0},
    '{ROW_WRITE, REG_BASE_ANCHOR_CODE, 18'h3FFFF, 1'b0, '0},
    '{ROW_PREDICT, '0, 18'd4095, 1'b0, '0},
    '{ROW_WRITE, REG_ACID_GAIN,        18'h1FFFF, 1'b0, '0},
    '{ROW_PREDICT, '0, 18'd2000, 1'b1, '0}
  };

  ph_sensor_average_calibrate #(
    .SAMPLES(GROUP_LEN)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .avg_code(avg_code),
    .ph_centi(ph_centi),
    .fault(fault),
    .category(category),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Maps a calibrated centi-pH value to its band.
  function automatic logic [CAT_W-1:0] ph_band(input logic [PH_W-1:0] ph);
    if (ph < 300) return CAT_VERY_ACID;
    if (ph < 500) return CAT_ACID;
    if (ph < 650) return CAT_SLIGHTLY_ACID;
    if (ph <= 750) return CAT_NEUTRAL;
    if (ph <= 900) return CAT_SLIGHTLY_BASE;
    if (ph <= 1200) return CAT_BASE;
    return CAT_VERY_BASE;
  endfunction

  // Full result for one averaged code under the current calibration. The
  // line is evaluated exactly in Q16, half a unit added, then floored, so it
  // rounds half up before the clamp to the 11-bit range.
  function automatic reading_t calibrate_avg(input logic [AVG_W-1:0] avg);
    reading_t r;
    longint   anchor_code;
    longint   anchor_ph;
    longint   gain;
    longint   v;
    if (avg >= cal.break_code) begin
      anchor_code = longint'(cal.break_code);
      anchor_ph   = longint'(cal.acid_anchor_ph);
      gain        = longint'($signed(cal.acid_gain));
    end else begin
      anchor_code = longint'(cal.base_anchor_code);
      anchor_ph   = longint'(cal.base_anchor_ph);
      gain        = longint'($signed(cal.base_gain));
    end
    v = anchor_ph * 65536 + gain * (longint'(avg) - anchor_code) + 32768;
    r.avg = avg;
    if (v < 0) begin
      r.ph = '0;
    end else if (v >= longint'(2048) * 65536) begin
      r.ph = '1;
    end else begin
      r.ph = v[26:16];
    end
    if (avg < AVG_LOW_LIMIT) begin
      r.fault = FAULT_LOW;
    end else if (avg > AVG_HIGH_LIMIT) begin
      r.fault = FAULT_HIGH;
    end else begin
      r.fault = FAULT_OK;
    end
    // A faulted reading still carries its pH, but the band is forced down.
    r.cat = (r.fault != FAULT_OK) ? CAT_VERY_ACID : ph_band(r.ph);
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("MISMATCH @%0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Offers one sample word and waits for it to be taken. On acceptance the
  // predictor folds it into the group; the last word of a group queues the
  // expected reading, either the typed one or the predicted one.
  task automatic drive_sample(input logic [SAMPLE_W-1:0] v, input bit use_known,
                              input reading_t known);
    reading_t r;
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= v;
    do @(posedge clk); while (!in_ready);
    grp_sum = grp_sum + SUM_W'(v);
    if (grp_count + 1 < GROUP_LEN) begin
      grp_count = grp_count + 1'b1;
    end else begin
      r = calibrate_avg(AVG_W'(grp_sum / GROUP_LEN));
      grp_sum   = '0;
      grp_count = '0;
      pending_readings.push_back(use_known ? known : r);
    end
  endtask

  // Drops the input channel and waits until the last group has left the pipeline.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes one register while the block is idle, and mirrors the write in
  // the predictor with the same truncation the block applies.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BREAK_CODE:       cal.break_code       = data[AVG_W-1:0];
      REG_ACID_ANCHOR_PH:   cal.acid_anchor_ph   = data[PH_W-1:0];
      REG_ACID_GAIN:        cal.acid_gain        = data[GAIN_W-1:0];
      REG_BASE_ANCHOR_CODE: cal.base_anchor_code = data[AVG_W-1:0];
      REG_BASE_ANCHOR_PH:   cal.base_anchor_ph   = data[PH_W-1:0];
      REG_BASE_GAIN:        cal.base_gain        = data[GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: drops out_ready at random about 29 percent of the time, except in the steady phase.
  always @(negedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 29);
  end

  // Every accepted result word is matched against the oldest expectation.
  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        flag_mismatch($sformatf("result word avg_code=%0d with nothing expected", avg_code));
      end else begin
        want = pending_readings.pop_front();
        if (avg_code !== want.avg)
          flag_mismatch($sformatf("avg_code %0d, expected %0d", avg_code, want.avg));
        if (ph_centi !== want.ph)
          flag_mismatch($sformatf("ph_centi %0d, expected %0d (avg %0d)",
                                  ph_centi, want.ph, want.avg));
        if (fault !== want.fault)
          flag_mismatch($sformatf("fault %0d, expected %0d (avg %0d)",
                                  fault, want.fault, want.avg));
        if (category !== want.cat)
          flag_mismatch($sformatf("category %0d, expected %0d (avg %0d)",
                                  category, want.cat, want.avg));
      end
    end
  end

  // Main sequence: reset, the directed plan, then four random phases of six
  // groups each. Phase 0 restores the default calibration, phase 1 uses a
  // plausible probe calibration with no idling on either side, phase 2 writes
  // raw 18-bit data everywhere, and phase 3 pins every register to an extreme.
  initial begin
    logic [CFG_DATA_W-1:0] words [6];
    logic [SAMPLE_W-1:0]   picks [8];
    int                    center;
    int                    s;
    int unsigned           style;
    logic [SAMPLE_W-1:0]   fixed;

    cal.break_code       = BREAK_CODE_RST;
    cal.acid_anchor_ph   = ACID_ANCHOR_PH_RST;
    cal.acid_gain        = ACID_GAIN_RST;
    cal.base_anchor_code = BASE_ANCHOR_CODE_RST;
    cal.base_anchor_ph   = BASE_ANCHOR_PH_RST;
    cal.base_gain        = BASE_GAIN_RST;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[n]) begin
      if (plan[n].kind == ROW_WRITE) begin
        cfg_write(plan[n].idx, plan[n].val);
      end else begin
        for (int i = 0; i < GROUP_LEN; i++) begin
          drive_sample(SAMPLE_W'(plan[n].val[SAMPLE_W-1:0] + (plan[n].ramp ? i : 0)),
                       plan[n].kind == ROW_KNOWN, plan[n].known);
        end
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          words[REG_BREAK_CODE]       = CFG_DATA_W'(BREAK_CODE_RST);
          words[REG_ACID_ANCHOR_PH]   = CFG_DATA_W'(ACID_ANCHOR_PH_RST);
          words[REG_ACID_GAIN]        = ACID_GAIN_RST;
          words[REG_BASE_ANCHOR_CODE] = CFG_DATA_W'(BASE_ANCHOR_CODE_RST);
          words[REG_BASE_ANCHOR_PH]   = CFG_DATA_W'(BASE_ANCHOR_PH_RST);
          words[REG_BASE_GAIN]        = BASE_GAIN_RST;
        end
        1: begin
          words[REG_BREAK_CODE]       = CFG_DATA_W'($urandom_range(2000, 3600));
          words[REG_ACID_ANCHOR_PH]   = CFG_DATA_W'($urandom_range(300, 900));
          words[REG_ACID_GAIN]        = CFG_DATA_W'(-int'($urandom_range(15000, 40000)));
          words[REG_BASE_ANCHOR_CODE] = CFG_DATA_W'($urandom_range(1500, 3000));
          words[REG_BASE_ANCHOR_PH]   = CFG_DATA_W'($urandom_range(800, 1200));
          words[REG_BASE_GAIN]        = CFG_DATA_W'(-int'($urandom_range(15000, 40000)));
        end
        2: begin
          foreach (words[r]) words[r] = CFG_DATA_W'($urandom());
        end
        default: begin
          words[REG_BREAK_CODE]       = 18'h3FFFF;
          words[REG_ACID_ANCHOR_PH]   = 18'h00000;
          words[REG_ACID_GAIN]        = 18'h1FFFF;
          words[REG_BASE_ANCHOR_CODE] = 18'h00000;
          words[REG_BASE_ANCHOR_PH]   = 18'h007FF;
          words[REG_BASE_GAIN]        = 18'h20000;
        end
      endcase
      for (int r = REG_BREAK_CODE; r <= REG_BASE_GAIN; r++) begin
        cfg_write(CFG_IDX_W'(r), words[r]);
      end
      if (phase == 2) begin
        cfg_write($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                  CFG_DATA_W'($urandom()));
      end

      // Constant groups at the code extremes, around a fault limit or on a segment anchor.
      picks = '{12'd0, 12'd4095, 12'd49, 12'd50, 12'd4000, 12'd4001,
                cal.break_code, cal.base_anchor_code};

      steady = (phase == 1);
      for (int g = 0; g < 6; g++) begin
        style  = $urandom_range(0, 9);
        center = int'($urandom_range(0, 4095));
        fixed  = picks[$urandom_range(0, 7)];
        for (int i = 0; i < GROUP_LEN; i++) begin
          if (style < 6) begin
            // A steady probe: readings scattered around one level.
            s = center + int'($urandom_range(0, 60)) - 30;
            if (s < 0) s = 0;
            if (s > 4095) s = 4095;
          end else if (style < 9) begin
            s = int'($urandom_range(0, 4095));
          end else begin
            s = int'(fixed);
          end
          drive_sample(SAMPLE_W'(s), 1'b0, '0);
        end
      end
      steady = 1'b0;
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("ph_sensor_average_calibrate_test: done, clean");
    end else begin
      $display("ph_sensor_average_calibrate_test: done, errors");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("ph_sensor_average_calibrate_test: done, errors");
    $finish;
  end

endmodule
